// File: rtl/core/sprite_frame_sequencer_assert.svh
// Assertion macros for the sprite frame sequencer.
// Used by the top level; no other dependencies. Empty when SYNTHESIS is set.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SFS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sprite_frame_sequencer: assertion failed");
// next-cycle implication, checked out of reset
`define SFS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sprite_frame_sequencer: assertion failed");
`else
`define SFS_ASSERT_NOW(label, pre, post)
`define SFS_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/core/sfs_pkg.sv
// Shared types and codes for the sprite frame sequencer.
// No dependencies; used by sfs_regs, sfs_list and sprite_frame_sequencer.
package sfs_pkg;

  localparam int FRAME_BITS = 8;
  localparam int COUNT_W    = FRAME_BITS + 1;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [COUNT_W-1:0] SHEET_MAX = COUNT_W'(1 << FRAME_BITS);

  // item modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_APPEND = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // animation kinds
  localparam logic [2:0] KIND_STATIC     = 3'd0;
  localparam logic [2:0] KIND_ONCE_DEL   = 3'd1;
  localparam logic [2:0] KIND_ONCE_PAUSE = 3'd2;
  localparam logic [2:0] KIND_ONCE_HIDE  = 3'd3;
  localparam logic [2:0] KIND_LOOP       = 3'd4;
  localparam logic [2:0] KIND_REVERSE    = 3'd5;
  localparam logic [2:0] KIND_CUSTOM     = 3'd6;

  // event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_END    = 2'd1;
  localparam logic [1:0] EV_DELETE = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [2:0] REG_RANGE_FIRST   = 3'd1;
  localparam logic [2:0] REG_RANGE_LAST    = 3'd2;
  localparam logic [2:0] REG_ANIM_KIND     = 3'd3;
  localparam logic [2:0] REG_RATE_TICKS    = 3'd4;
  localparam logic [2:0] REG_REPEAT_LIMIT  = 3'd5;
  localparam logic [2:0] REG_RESTART_TICKS = 3'd6;
  localparam logic [2:0] REG_DELAY_TICKS   = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0]    frame_count;
    logic [FRAME_BITS-1:0] range_first;
    logic signed [8:0]     range_last;
    logic [2:0]            anim_kind;
    logic [15:0]           rate_ticks;
    logic [15:0]           repeat_limit;
    logic [15:0]           restart_ticks;
    logic [15:0]           delay_ticks;
  } cfg_t;

endpackage

// File: rtl/core/sfs_regs.sv
// Configuration register file of the sprite frame sequencer, APB-style port.
// Depends on sfs_pkg for the register indexes and the cfg_t bundle.
module sfs_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [sfs_pkg::DATA_W-1:0]   pwdata,
  output logic [sfs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output sfs_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_count   <= '0;
      cfg.range_first   <= '0;
      cfg.range_last    <= 9'h1FF;
      cfg.anim_kind     <= sfs_pkg::KIND_STATIC;
      cfg.rate_ticks    <= '0;
      cfg.repeat_limit  <= 16'd1;
      cfg.restart_ticks <= '0;
      cfg.delay_ticks   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sfs_pkg::REG_FRAME_COUNT:   cfg.frame_count   <= pwdata[8:0];
        sfs_pkg::REG_RANGE_FIRST:   cfg.range_first   <= pwdata[7:0];
        sfs_pkg::REG_RANGE_LAST:    cfg.range_last    <= pwdata[8:0];
        sfs_pkg::REG_ANIM_KIND:     cfg.anim_kind     <= pwdata[2:0];
        sfs_pkg::REG_RATE_TICKS:    cfg.rate_ticks    <= pwdata[15:0];
        sfs_pkg::REG_REPEAT_LIMIT:  cfg.repeat_limit  <= pwdata[15:0];
        sfs_pkg::REG_RESTART_TICKS: cfg.restart_ticks <= pwdata[15:0];
        sfs_pkg::REG_DELAY_TICKS:   cfg.delay_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      sfs_pkg::REG_FRAME_COUNT:   prdata = 32'(cfg.frame_count);
      sfs_pkg::REG_RANGE_FIRST:   prdata = 32'(cfg.range_first);
      sfs_pkg::REG_RANGE_LAST:    prdata = 32'(unsigned'(cfg.range_last));
      sfs_pkg::REG_ANIM_KIND:     prdata = 32'(cfg.anim_kind);
      sfs_pkg::REG_RATE_TICKS:    prdata = 32'(cfg.rate_ticks);
      sfs_pkg::REG_REPEAT_LIMIT:  prdata = 32'(cfg.repeat_limit);
      sfs_pkg::REG_RESTART_TICKS: prdata = 32'(cfg.restart_ticks);
      sfs_pkg::REG_DELAY_TICKS:   prdata = 32'(cfg.delay_ticks);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/sfs_list.sv
// Custom frame list storage: one write port, a prefetched read port and a
// copy of the head entry. Depends on sfs_pkg for the frame width.
module sfs_list #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH+1)-1:0]       wr_pos,
  input  logic [sfs_pkg::FRAME_BITS-1:0]   wr_frame,
  input  logic [$clog2(DEPTH+1)-1:0]       rd_pos,
  output logic [sfs_pkg::FRAME_BITS-1:0]   head_frame,
  output logic [sfs_pkg::FRAME_BITS-1:0]   rd_frame
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [sfs_pkg::FRAME_BITS-1:0] mem [DEPTH];

  // write port; entry 0 is mirrored for the start of a custom run
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[IDX_W-1:0]] <= wr_frame;
      if (wr_pos == CNT_W'(0)) begin
        head_frame <= wr_frame;
      end
    end
  end

  // registered read at the list position the next item will see,
  // with bypass of a write landing on that same entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_pos == rd_pos)) begin
      rd_frame <= wr_frame;
    end else begin
      rd_frame <= mem[rd_pos[IDX_W-1:0]];
    end
  end

endmodule

// File: rtl/core/sprite_frame_sequencer.sv
// Sprite animation frame sequencer, top level.
// Depends on sfs_pkg, sfs_regs, sfs_list and sprite_frame_sequencer_assert.svh.
//
// Input channel (in_valid/in_ready) carries one beat per command: mode 0 tick,
// 1 start animation, 2 append frame_value to the custom list, 3 clear the list.
// Output channel (out_valid/out_ready) returns one beat per command with the
// state after it: current_frame, shown, halted, event_code and append_ok.
// Every command is worked in the cycle it is accepted; its result sits in the
// output register in the next cycle, and throughput is one beat per cycle
// while the receiver keeps up. The output register is the only buffer: a
// command is taken whenever it is empty or being drained in the same cycle,
// so a stalled receiver holds off the sender until its beat is taken.
// Configuration goes through the APB-style port (8 registers at 4*i); the user
// must write it only while the block is idle; the block does not enforce it.
// Rate, restart and sheet size act live. Synchronous reset: animation paused
// and visible, frame 0, empty custom list, no result pending. The list memory
// keeps no reset; only written entries are ever read back.
`include "sprite_frame_sequencer_assert.svh"
module sprite_frame_sequencer #(
  parameter int CUSTOM_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [7:0]                   frame_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   current_frame,
  output logic                         shown,
  output logic                         halted,
  output logic [1:0]                   event_code,
  output logic                         append_ok,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [sfs_pkg::DATA_W-1:0]   pwdata,
  output logic [sfs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int FB    = sfs_pkg::FRAME_BITS;
  localparam int CW    = sfs_pkg::COUNT_W;
  localparam int CNT_W = $clog2(CUSTOM_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(CUSTOM_DEPTH);

  sfs_pkg::cfg_t cfg;

  // animation state
  logic [FB-1:0]    frame_now, frame_now_next;
  logic [FB-1:0]    first_eff, first_eff_next;
  logic [FB-1:0]    last_eff, last_eff_next;
  logic             step_backward, step_backward_next;
  logic             paused, paused_next;
  logic             visible, visible_next;
  logic [15:0]      repeats_left, repeats_next;
  logic [15:0]      delay_left, delay_next;
  logic [15:0]      rate_count, rate_next;
  logic [15:0]      restart_count, restart_next;
  logic [CNT_W-1:0] custom_len, custom_len_next;
  logic [CNT_W-1:0] custom_pos, custom_pos_next;
  logic [2:0]       kind_run, kind_run_next;

  logic             accept;
  logic [1:0]       ev;
  logic             ok;
  logic             list_we;
  logic             step_go;
  logic             at_end;
  logic [15:0]      rc1, rt1;
  logic [FB-1:0]    head_frame, rd_frame;

  // start-time range clamp
  logic [CW-1:0]    n_eff;
  logic             n_multi;
  logic [FB-1:0]    top_frame;
  logic [FB-1:0]    last_req;

  function automatic logic [FB-1:0] valid_frame(input logic [FB-1:0] f,
                                                input logic [CW-1:0] n);
    return ({1'b0, f} < n) ? f : '0;
  endfunction

  function automatic logic [FB-1:0] advance(input logic [FB-1:0] f, input logic back);
    return back ? (f - FB'(1)) : (f + FB'(1));
  endfunction

  sfs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfs_list #(.DEPTH(CUSTOM_DEPTH)) u_list (
    .clk        (clk),
    .wr_en      (list_we),
    .wr_pos     (custom_len),
    .wr_frame   (frame_value),
    .rd_pos     (custom_pos_next),
    .head_frame (head_frame),
    .rd_frame   (rd_frame)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign n_eff     = (cfg.frame_count > sfs_pkg::SHEET_MAX) ? sfs_pkg::SHEET_MAX
                                                            : cfg.frame_count;
  assign n_multi   = n_eff > CW'(1);
  assign top_frame = (n_eff != '0) ? FB'(n_eff - CW'(1)) : '0;
  assign last_req  = cfg.range_last[8] ? top_frame : cfg.range_last[FB-1:0];
  assign rc1       = restart_count + 16'd1;
  assign rt1       = rate_count + 16'd1;

  // next-state logic for one command
  always_comb begin
    frame_now_next     = frame_now;
    first_eff_next     = first_eff;
    last_eff_next      = last_eff;
    step_backward_next = step_backward;
    paused_next        = paused;
    visible_next       = visible;
    repeats_next       = repeats_left;
    delay_next         = delay_left;
    rate_next          = rate_count;
    restart_next       = restart_count;
    custom_len_next    = custom_len;
    custom_pos_next    = custom_pos;
    kind_run_next      = kind_run;
    ev                 = sfs_pkg::EV_NONE;
    ok                 = 1'b0;
    list_we            = 1'b0;
    step_go            = 1'b0;
    at_end             = 1'b0;

    if (accept) begin
      case (mode)
        sfs_pkg::MODE_TICK: begin
          if (delay_left != 16'd0) begin
            delay_next = delay_left - 16'd1;
          end else begin
            // periodic restart
            if (cfg.restart_ticks != 16'd0) begin
              if (rc1 >= cfg.restart_ticks) begin
                restart_next   = '0;
                frame_now_next = valid_frame(first_eff, n_eff);
                paused_next    = 1'b0;
                visible_next   = 1'b1;
              end else begin
                restart_next = rc1;
              end
            end
            // rate divider
            step_go = 1'b1;
            if (cfg.rate_ticks != 16'd0) begin
              if (rt1 < cfg.rate_ticks) begin
                rate_next = rt1;
                step_go   = 1'b0;
              end else begin
                rate_next = '0;
              end
            end
            // frame step
            if (step_go && n_multi && !paused_next) begin
              at_end = step_backward ? (frame_now_next <= first_eff)
                                     : (frame_now_next >= last_eff);
              case (kind_run)
                sfs_pkg::KIND_ONCE_DEL, sfs_pkg::KIND_ONCE_PAUSE,
                sfs_pkg::KIND_ONCE_HIDE: begin
                  if (at_end) begin
                    paused_next = 1'b1;
                    if (kind_run == sfs_pkg::KIND_ONCE_HIDE) visible_next = 1'b0;
                    ev = (kind_run == sfs_pkg::KIND_ONCE_DEL) ? sfs_pkg::EV_DELETE
                                                              : sfs_pkg::EV_END;
                  end else begin
                    frame_now_next = advance(frame_now_next, step_backward);
                  end
                end
                sfs_pkg::KIND_LOOP: begin
                  if (at_end) begin
                    if (repeats_left != 16'd0) begin
                      repeats_next = repeats_left - 16'd1;
                      if (repeats_left == 16'd1) paused_next = 1'b1;
                    end
                    frame_now_next = step_backward ? last_eff : first_eff;
                    ev = sfs_pkg::EV_END;
                  end else begin
                    frame_now_next = advance(frame_now_next, step_backward);
                  end
                end
                sfs_pkg::KIND_REVERSE: begin
                  if (at_end && (repeats_left == 16'd1)) begin
                    // last pass used up: stop where we are
                    repeats_next = '0;
                    paused_next  = 1'b1;
                  end else if (at_end) begin
                    if (repeats_left != 16'd0) repeats_next = repeats_left - 16'd1;
                    step_backward_next = !step_backward;
                    ev = sfs_pkg::EV_END;
                    frame_now_next = advance(frame_now_next, !step_backward);
                  end else begin
                    frame_now_next = advance(frame_now_next, step_backward);
                  end
                end
                sfs_pkg::KIND_CUSTOM: begin
                  if ((custom_pos >= custom_len) || (custom_pos >= DEPTH_C)) begin
                    paused_next = 1'b1;
                    ev = sfs_pkg::EV_END;
                  end else begin
                    frame_now_next  = rd_frame;
                    custom_pos_next = custom_pos + CNT_W'(1);
                  end
                end
                default: ;
              endcase
            end
          end
        end
        sfs_pkg::MODE_START: begin
          // a custom start on an empty list is a no-op
          if (!((cfg.anim_kind == sfs_pkg::KIND_CUSTOM) && (custom_len == '0))) begin
            if (cfg.anim_kind == sfs_pkg::KIND_CUSTOM) begin
              custom_pos_next = '0;
              frame_now_next  = valid_frame(head_frame, n_eff);
            end else begin
              first_eff_next = ({1'b0, cfg.range_first} >= n_eff) ? '0 : cfg.range_first;
              last_eff_next  = ({1'b0, last_req} >= n_eff) ? top_frame : last_req;
              step_backward_next = !(first_eff_next < last_eff_next);
              frame_now_next = valid_frame(cfg.range_first, n_eff);
            end
            kind_run_next = cfg.anim_kind;
            rate_next     = '0;
            restart_next  = '0;
            delay_next    = cfg.delay_ticks;
            repeats_next  = cfg.repeat_limit;
            paused_next   = !n_multi;
          end
        end
        sfs_pkg::MODE_APPEND: begin
          if (({1'b0, frame_value} < n_eff) && (custom_len < DEPTH_C)) begin
            list_we         = 1'b1;
            custom_len_next = custom_len + CNT_W'(1);
            ok              = 1'b1;
          end
        end
        sfs_pkg::MODE_CLEAR: begin
          custom_len_next = '0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_now     <= '0;
      first_eff     <= '0;
      last_eff      <= '0;
      step_backward <= 1'b0;
      paused        <= 1'b1;
      visible       <= 1'b1;
      repeats_left  <= 16'd1;
      delay_left    <= '0;
      rate_count    <= '0;
      restart_count <= '0;
      custom_len    <= '0;
      custom_pos    <= '0;
      kind_run      <= sfs_pkg::KIND_STATIC;
    end else begin
      frame_now     <= frame_now_next;
      first_eff     <= first_eff_next;
      last_eff      <= last_eff_next;
      step_backward <= step_backward_next;
      paused        <= paused_next;
      visible       <= visible_next;
      repeats_left  <= repeats_next;
      delay_left    <= delay_next;
      rate_count    <= rate_next;
      restart_count <= restart_next;
      custom_len    <= custom_len_next;
      custom_pos    <= custom_pos_next;
      kind_run      <= kind_run_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      current_frame <= frame_now_next;
      shown         <= visible_next;
      halted        <= paused_next;
      event_code    <= ev;
      append_ok     <= ok;
    end
  end

  // checks
  `SFS_ASSERT_NOW(a_len_bound, 1'b1, custom_len <= DEPTH_C)
  `SFS_ASSERT_NEXT(a_event_tick_only, accept && (mode != sfs_pkg::MODE_TICK), out_valid && (event_code == sfs_pkg::EV_NONE))
  `SFS_ASSERT_NEXT(a_ok_append_only, accept && (mode != sfs_pkg::MODE_APPEND), out_valid && !append_ok)
  `SFS_ASSERT_NEXT(a_append_grows, accept && (mode == sfs_pkg::MODE_APPEND) && ok, custom_len == $past(custom_len) + CNT_W'(1))

endmodule
